// ===== hw/rtl/dps_pkg.sv =====
package dps_pkg;

  localparam int unsigned DefaultDepth = 64;

  localparam logic [2:0] OpInsert = 3'd0;
  localparam logic [2:0] OpHighSeq = 3'd1;
  localparam logic [2:0] OpClearSeq = 3'd2;
  localparam logic [2:0] OpTakeOldest = 3'd3;
  localparam logic [2:0] OpCount = 3'd4;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusDup = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;
  localparam logic [1:0] StatusNone = 2'd3;

  localparam logic [1:0] KindData = 2'd0;
  localparam logic [1:0] KindAck = 2'd1;

  // One stored descriptor.
  typedef struct packed {
    logic [31:0] source;
    logic [31:0] dest;
    logic [15:0] seq;
    logic [1:0]  kind;
    logic [15:0] handle;
    logic [31:0] stamp;
  } entry_t;

  // Packed input item.
  typedef struct packed {
    logic        any_source;
    logic [15:0] handle_in;
    logic [1:0]  kind_in;
    logic [15:0] seq_in;
    logic [31:0] dest_addr;
    logic [31:0] source_addr;
    logic [2:0]  op;
  } req_t;

  // Packed result item.
  typedef struct packed {
    logic [6:0]  ack_count;
    logic [6:0]  data_count;
    logic [15:0] out_handle;
    logic [1:0]  out_kind;
    logic [15:0] out_seq;
    logic [31:0] out_dest;
    logic [31:0] out_source;
    logic [15:0] high_seq;
    logic [1:0]  status;
  } rsp_t;

endpackage

// ===== hw/rtl/dps_slot_mem.sv =====
module dps_slot_mem #(
  parameter int unsigned Depth = dps_pkg::DefaultDepth
) (
  input  logic                        clk_i,
  input  logic [$clog2(Depth)-1:0]    raddr_i,
  output dps_pkg::entry_t             rdata_o,
  input  logic                        we_i,
  input  logic [$clog2(Depth)-1:0]    waddr_i,
  input  dps_pkg::entry_t             wdata_i
);
  import dps_pkg::*;

  entry_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/dedup_packet_store.sv =====
// An accepted operation makes one scan pass over the slot memory, one read per
// cycle, then a done step that writes back and loads the result register, then
// the result is offered. The input opens again only after the result is taken,
// so a new operation is not accepted while the last one is still in flight.
// Reset clears all valid bits, the arrival counter and the control state.
module dedup_packet_store #(
  parameter int unsigned Depth = dps_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // op[2:0], source_addr[34:3], dest_addr[66:35], seq_in[82:67],
  // kind_in[84:83], handle_in[100:85], any_source[101], zero fill to 103
  input  logic [103:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[1:0], high_seq[17:2], out_source[49:18], out_dest[81:50],
  // out_seq[97:82], out_kind[99:98], out_handle[115:100],
  // data_count[122:116], ack_count[129:123], zero fill to 135
  output logic [135:0] m_axis_tdata_o
);
  import dps_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]  state_q, state_d;
  req_t        req_q;
  logic [AW:0] rd_cnt_q;   // next address to issue
  logic [AW:0] ev_cnt_q;   // address whose data is on rdata
  logic        ev_vld_q;
  logic [Depth-1:0] valid_q;
  logic [31:0] arrival_q;

  // Scan accumulators.
  logic          dup_q, free_found_q, hit_q;
  logic [AW-1:0] free_slot_q, best_q;
  logic [31:0]   best_age_q;
  entry_t        best_e_q;
  logic [15:0]   high_q;
  logic [CW-1:0] nd_q, na_q;
  rsp_t          rsp_q;
  rsp_t          rsp_d;

  entry_t        rdata;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] ev_idx;
  logic          ev_valid, src_eq, pair_eq;
  logic [31:0]   ev_age;

  assign ev_idx   = ev_cnt_q[AW-1:0];
  assign ev_valid = valid_q[ev_idx];
  assign src_eq   = rdata.source == req_q.source_addr;
  assign pair_eq  = src_eq && (rdata.dest == req_q.dest_addr);
  assign ev_age   = arrival_q - rdata.stamp;

  // Clear sequence writes back during the scan; an entry is read once, so
  // there is no overlap on the same slot. Insert writes at the done step.
  always_comb begin
    we    = 1'b0;
    waddr = ev_idx;
    wdata = rdata;
    wdata.seq = 16'd0;
    if (state_q == StScan && ev_vld_q && req_q.op == OpClearSeq && ev_valid
        && pair_eq && rdata.kind == req_q.kind_in) begin
      we = 1'b1;
    end else if (state_q == StDone && req_q.op == OpInsert && !dup_q
                 && free_found_q) begin
      we = 1'b1;
      waddr = free_slot_q;
      wdata.source = req_q.source_addr;
      wdata.dest   = req_q.dest_addr;
      wdata.seq    = req_q.seq_in;
      wdata.kind   = req_q.kind_in;
      wdata.handle = req_q.handle_in;
      wdata.stamp  = arrival_q;
    end
  end

  dps_slot_mem #(.Depth(Depth)) u_mem (
    .clk_i   (clk_i),
    .raddr_i (rd_cnt_q[AW-1:0]),
    .rdata_o (rdata),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata)
  );

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = (state_q == StOut);
  assign m_axis_tdata_o  = {6'd0, rsp_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (s_axis_tvalid_i) state_d = StScan;
      StScan: if (ev_vld_q && ev_cnt_q == (AW+1)'(Depth - 1)) state_d = StDone;
      StDone: state_d = StOut;
      StOut:  if (m_axis_tready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // The result of the finished scan, loaded into the result register at the done step.
  always_comb begin
    rsp_d = '0;
    case (req_q.op)
      OpInsert: begin
        if (dup_q) rsp_d.status = StatusDup;
        else if (!free_found_q) rsp_d.status = StatusFull;
      end
      OpHighSeq: rsp_d.high_seq = high_q;
      OpTakeOldest: begin
        if (!hit_q) rsp_d.status = StatusNone;
        else begin
          rsp_d.out_source = best_e_q.source;
          rsp_d.out_dest   = best_e_q.dest;
          rsp_d.out_seq    = best_e_q.seq;
          rsp_d.out_kind   = best_e_q.kind;
          rsp_d.out_handle = best_e_q.handle;
        end
      end
      OpCount: begin
        rsp_d.data_count = 7'(nd_q);
        rsp_d.ack_count  = 7'(na_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      valid_q   <= '0;
      arrival_q <= '0;
      rd_cnt_q  <= '0;
      ev_cnt_q  <= '0;
      ev_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          // The read address stays at slot zero until a transaction is accepted.
          rd_cnt_q <= s_axis_tvalid_i ? (AW+1)'(1) : '0;
          ev_cnt_q <= '0;
          ev_vld_q <= s_axis_tvalid_i;
        end
        StScan: begin
          if (rd_cnt_q != (AW+1)'(Depth)) rd_cnt_q <= rd_cnt_q + 1'b1;
          ev_cnt_q <= ev_cnt_q + 1'b1;
          ev_vld_q <= (ev_cnt_q != (AW+1)'(Depth - 1));
        end
        StDone: begin
          rd_cnt_q <= '0;
          if (req_q.op == OpInsert && !dup_q && free_found_q) begin
            valid_q[free_slot_q] <= 1'b1;
            arrival_q <= arrival_q + 32'd1;
          end else if (req_q.op == OpTakeOldest && hit_q) begin
            valid_q[best_q] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && s_axis_tvalid_i) begin
      req_q        <= req_t'(s_axis_tdata_i[101:0]);
      dup_q        <= 1'b0;
      free_found_q <= 1'b0;
      hit_q        <= 1'b0;
      free_slot_q  <= '0;
      best_q       <= '0;
      best_age_q   <= '0;
      best_e_q     <= '0;
      high_q       <= '0;
      nd_q         <= '0;
      na_q         <= '0;
    end else if (state_q == StScan && ev_vld_q) begin
      if (ev_valid) begin
        if (pair_eq && rdata.seq == req_q.seq_in && rdata.kind == req_q.kind_in)
          dup_q <= 1'b1;
        if (pair_eq && rdata.seq > high_q) high_q <= rdata.seq;
        if ((req_q.any_source || src_eq) && (!hit_q || ev_age > best_age_q)) begin
          hit_q      <= 1'b1;
          best_q     <= ev_idx;
          best_age_q <= ev_age;
          best_e_q   <= rdata;
        end
        if (rdata.kind == KindData) nd_q <= nd_q + 1'b1;
        else if (rdata.kind == KindAck) na_q <= na_q + 1'b1;
      end else if (!free_found_q) begin
        free_found_q <= 1'b1;
        free_slot_q  <= ev_idx;
      end
    end else if (state_q == StDone) begin
      rsp_q <= rsp_d;
    end
  end

  // The input is never open while the result is offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input and output both open");

  // A scan walks every slot before the done step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |-> $past(ev_cnt_q) == (AW+1)'(Depth - 1))
    else $error("scan ended early");

  // The arrival counter moves only by a successful insert.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (arrival_q != $past(arrival_q)) |-> $past(state_q) == StDone
      && $past(req_q.op) == OpInsert)
    else $error("arrival counter moved without insert");

endmodule
